@@ design/ssr_pkg.sv @@
// Shared constants, types and sizing functions for the streaming substring replacer.
// Used by ssr_front, ssr_back and the top level; depends on nothing else.
`default_nettype none

package ssr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PATTERN = 8;
    localparam int DEF_CHAR_BITS   = 8;
    localparam int DEF_MAX_LENGTH  = 65536;

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH = 4;

    // The replacement text holds at most eight characters.
    localparam int REPL_MAX = 8;

    // Fixed register and field widths.
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_W       = 4;
    localparam int CAP_W       = 17;
    localparam int OUT_LEN_W   = 16;

    localparam logic [CAP_W-1:0] CAP_RESET     = 17'h10000;
    localparam logic [LEN_W-1:0] PLEN_RESET    = 4'd1;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_CHARS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_CHARS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_CAPACITY    = 3'd4;

    // What a command asks the back to emit before any end-of-string flush.
    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_CHAR = 2'd1;
    localparam logic [1:0] LEAD_REPL = 2'd2;

    // Effective (clamped) lengths, shared by the front and the back.
    typedef struct packed {
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] rlen;
    } t_lens;

    // Width of the saturating character and match counters.
    function automatic int cnt_width(input int max_length);
        return $clog2(max_length + 1);
    endfunction

    // Width of the window fill count.
    function automatic int wcnt_width(input int max_pattern);
        return $clog2(max_pattern + 1);
    endfunction

    // Width of a command: lead kind, lead char, end flag, window, window count, two counters.
    function automatic int cmd_width(input int max_pattern, input int char_bits,
                                     input int max_length);
        return 2 + char_bits + 1 + max_pattern * char_bits + wcnt_width(max_pattern)
               + 2 * cnt_width(max_length);
    endfunction

endpackage

`default_nettype wire

@@ design/ssr_cmd_fifo.sv @@
// Small first-in first-out queue of commands between the front and the back.
// Flip-flop storage, one write and one read port; uses no package items.
`default_nettype none

module ssr_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/ssr_front.sv @@
// Front of the replacer: keeps the undecided window and the counters, matches the pattern
// and turns every accepted beat into at most one command. Depends on ssr_pkg.
`default_nettype none

module ssr_front #(
    parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN,
    parameter int CHAR_BITS   = ssr_pkg::DEF_CHAR_BITS,
    parameter int MAX_LENGTH  = ssr_pkg::DEF_MAX_LENGTH,
    localparam int CMD_W = ssr_pkg::cmd_width(MAX_PATTERN, CHAR_BITS, MAX_LENGTH)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_clear,
    input  wire ssr_pkg::t_lens                     i_lens,
    input  wire logic [MAX_PATTERN*CHAR_BITS-1:0]   i_pattern,
    input  wire logic                               i_accept,
    input  wire logic [CHAR_BITS-1:0]               i_in_char,
    input  wire logic                               i_char_present,
    input  wire logic                               i_end_of_string,
    output logic                                    o_cmd_valid,
    output logic [CMD_W-1:0]                        o_cmd
);

    localparam int CW  = ssr_pkg::cnt_width(MAX_LENGTH);
    localparam int PLW = ssr_pkg::wcnt_width(MAX_PATTERN);
    localparam int WIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CHAR_BITS-1:0] r_win [MAX_PATTERN];
    logic [PLW-1:0]       r_wcnt;
    logic [CW-1:0]        r_lcnt;
    logic [CW-1:0]        r_mcnt;

    logic [CHAR_BITS-1:0] w_ins   [MAX_PATTERN];
    logic [CHAR_BITS-1:0] w_after [MAX_PATTERN];
    logic [MAX_PATTERN*CHAR_BITS-1:0] win_flat;
    logic [PLW-1:0]       wc_inc, cnt_after;
    logic [CW-1:0]        l_after, m_after;
    logic                 full_win, hit;
    logic [1:0]           kind;
    logic [CHAR_BITS-1:0] lead_char;

    // Window with the new character dropped in at the fill position.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_ins[i] = (r_wcnt[WIW-1:0] == WIW'(i)) ? i_in_char : r_win[i];
        end
    end

    assign wc_inc   = r_wcnt + 1'b1;
    assign full_win = (wc_inc == i_lens.plen[PLW-1:0]);

    // Positions at or beyond the pattern length always agree.
    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((ssr_pkg::LEN_W'(i) < i_lens.plen)
                && (w_ins[i] != i_pattern[i*CHAR_BITS +: CHAR_BITS])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        kind      = ssr_pkg::LEAD_NONE;
        lead_char = w_ins[0];
        cnt_after = r_wcnt;
        m_after   = r_mcnt;
        l_after   = r_lcnt;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_after[i] = r_win[i];
        end
        if (i_char_present) begin
            if (r_lcnt != CW'(MAX_LENGTH)) begin
                l_after = r_lcnt + 1'b1;
            end
            if (full_win && hit) begin
                kind      = ssr_pkg::LEAD_REPL;
                cnt_after = '0;
                if (r_mcnt != CW'(MAX_LENGTH)) begin
                    m_after = r_mcnt + 1'b1;
                end
            end else if (full_win) begin
                // Oldest character is decided; the rest slide down by one.
                kind      = ssr_pkg::LEAD_CHAR;
                cnt_after = r_wcnt;
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    w_after[i] = w_ins[i+1];
                end
            end else begin
                cnt_after = wc_inc;
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    w_after[i] = w_ins[i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_flat[i*CHAR_BITS +: CHAR_BITS] = w_after[i];
        end
    end

    assign o_cmd_valid = i_accept && ((kind != ssr_pkg::LEAD_NONE) || i_end_of_string);
    assign o_cmd = {kind, lead_char, i_end_of_string, win_flat, cnt_after, l_after, m_after};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
            r_lcnt <= '0;
            r_mcnt <= '0;
        end else if (i_clear) begin
            r_wcnt <= '0;
            r_lcnt <= '0;
            r_mcnt <= '0;
        end else if (i_accept) begin
            if (i_end_of_string) begin
                r_wcnt <= '0;
                r_lcnt <= '0;
                r_mcnt <= '0;
            end else begin
                r_wcnt <= cnt_after;
                r_lcnt <= l_after;
                r_mcnt <= m_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= w_after[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/ssr_back.sv @@
// Back of the replacer: expands each queued command into result beats, one per cycle while
// the output register is empty or popped; computes final status and length. Depends on ssr_pkg.
`default_nettype none

module ssr_back #(
    parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN,
    parameter int CHAR_BITS   = ssr_pkg::DEF_CHAR_BITS,
    parameter int MAX_LENGTH  = ssr_pkg::DEF_MAX_LENGTH,
    localparam int CMD_W = ssr_pkg::cmd_width(MAX_PATTERN, CHAR_BITS, MAX_LENGTH)
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire ssr_pkg::t_lens                            i_lens,
    input  wire logic [ssr_pkg::REPL_MAX*CHAR_BITS-1:0]    i_repl,
    input  wire logic [ssr_pkg::CAP_W-1:0]                 i_capacity,
    input  wire logic [CMD_W-1:0]                          i_cmd,
    input  wire logic                                      i_cmd_empty,
    output logic                                           o_cmd_pop,
    input  wire logic                                      pop,
    output logic                                           empty,
    output logic [CHAR_BITS-1:0]                           o_out_char,
    output logic                                           o_out_present,
    output logic                                           o_final_item,
    output logic                                           o_status,
    output logic [ssr_pkg::OUT_LEN_W-1:0]                  o_result_length
);

    localparam int CW   = ssr_pkg::cnt_width(MAX_LENGTH);
    localparam int PLW  = ssr_pkg::wcnt_width(MAX_PATTERN);
    localparam int KW   = $clog2(ssr_pkg::REPL_MAX + MAX_PATTERN + 2);
    localparam int CWX  = (CW > ssr_pkg::CAP_W) ? CW : ssr_pkg::CAP_W;
    localparam int SW   = CWX + 6;
    localparam int RIW  = $clog2(ssr_pkg::REPL_MAX);

    logic [1:0]                       c_kind;
    logic [CHAR_BITS-1:0]             c_lead;
    logic                             c_end;
    logic [MAX_PATTERN*CHAR_BITS-1:0] c_win;
    logic [PLW-1:0]                   c_wcnt;
    logic [CW-1:0]                    c_lcnt, c_mcnt;

    assign {c_kind, c_lead, c_end, c_win, c_wcnt, c_lcnt, c_mcnt} = i_cmd;

    logic [KW-1:0] r_k, n_k;
    logic          r_ovalid;
    logic [KW-1:0] nl, nf, nt, fj;
    logic          can_load, beat, last_beat;

    logic [CHAR_BITS-1:0]          b_char;
    logic                          b_present, b_final, b_status;
    logic [ssr_pkg::OUT_LEN_W-1:0] b_len;

    logic signed [SW-1:0] l_s, m_s, d_s, cap_s, prod, sum_one, sum_all;

    assign empty    = !r_ovalid;
    assign can_load = !r_ovalid || pop;

    // Beats of one command: lead text, then window flush and the final beat at end of string.
    always_comb begin
        case (c_kind)
            ssr_pkg::LEAD_CHAR: nl = KW'(1);
            ssr_pkg::LEAD_REPL: nl = KW'(i_lens.rlen);
            default:            nl = '0;
        endcase
    end
    assign nf = c_end ? KW'(c_wcnt) : '0;
    assign nt = nl + nf + KW'(c_end);
    assign fj = r_k - nl;

    assign beat      = !i_cmd_empty && can_load && (nt != '0);
    assign last_beat = (r_k + 1'b1 == nt);
    assign o_cmd_pop = !i_cmd_empty && can_load && ((nt == '0) || last_beat);

    always_comb begin
        n_k = r_k;
        if (beat) begin
            n_k = last_beat ? '0 : r_k + 1'b1;
        end
    end

    // Final status: the buffer check at the first and at the last replacement.
    assign l_s     = $signed({{(SW-CW){1'b0}}, c_lcnt});
    assign m_s     = $signed({{(SW-CW){1'b0}}, c_mcnt});
    assign d_s     = $signed({{(SW-ssr_pkg::LEN_W){1'b0}}, i_lens.rlen})
                   - $signed({{(SW-ssr_pkg::LEN_W){1'b0}}, i_lens.plen});
    assign cap_s   = $signed({{(SW-ssr_pkg::CAP_W){1'b0}}, i_capacity});
    assign prod    = m_s * d_s;
    assign sum_one = l_s + d_s;
    assign sum_all = l_s + prod;

    always_comb begin
        b_char    = '0;
        b_present = 1'b0;
        b_final   = 1'b0;
        b_status  = 1'b0;
        b_len     = '0;
        if (r_k < nl) begin
            b_present = 1'b1;
            if (c_kind == ssr_pkg::LEAD_CHAR) begin
                b_char = c_lead;
            end else begin
                b_char = i_repl[r_k[RIW-1:0]*CHAR_BITS +: CHAR_BITS];
            end
        end else if (r_k < nl + nf) begin
            b_present = 1'b1;
            b_char    = c_win[fj*CHAR_BITS +: CHAR_BITS];
        end else begin
            b_final  = 1'b1;
            b_status = (c_mcnt != '0) && ((sum_one >= cap_s) || (sum_all >= cap_s));
            if (sum_all < 0) begin
                b_len = '0;
            end else if (sum_all > $signed(SW'(ssr_pkg::OUT_LEN_MAX))) begin
                b_len = ssr_pkg::OUT_LEN_MAX;
            end else begin
                b_len = sum_all[ssr_pkg::OUT_LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_k <= n_k;
            if (beat) begin
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            o_out_char      <= b_char;
            o_out_present   <= b_present;
            o_final_item    <= b_final;
            o_status        <= b_status;
            o_result_length <= b_len;
        end
    end

endmodule

`default_nettype wire

@@ design/stream_substring_replace.sv @@
// Streaming replace-all of a fixed pattern: top level with the configuration registers.
// Instantiates ssr_front, ssr_cmd_fifo and ssr_back; depends on ssr_pkg.
//
// One character is accepted per cycle on the push side while full is low, and one result
// beat leaves per cycle on the pop side while pop is held. An input beat that completes a
// match produces as many result beats as the replacement is long, and an end-of-string beat
// produces the undecided window plus one final beat carrying status and length; those bursts
// wait in a four-deep command queue between the matcher and the expander, so full rises only
// when the expander, which takes one command at a time, falls four commands behind. Commands
// are registered in the queue and result beats in the expander's output register. Writing the
// pattern or its length starts a new string; configuration is meant to be written idle.
`default_nettype none

module stream_substring_replace #(
    parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN,
    parameter int CHAR_BITS   = ssr_pkg::DEF_CHAR_BITS,
    parameter int MAX_LENGTH  = ssr_pkg::DEF_MAX_LENGTH,
    localparam int TEXT_W = ssr_pkg::REPL_MAX * CHAR_BITS,
    localparam int CFG_W  = (TEXT_W > ssr_pkg::CAP_W) ? TEXT_W : ssr_pkg::CAP_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ssr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]                  i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [CHAR_BITS-1:0]              i_in_char,
    input  wire logic                              i_char_present,
    input  wire logic                              i_end_of_string,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic [CHAR_BITS-1:0]                   o_out_char,
    output logic                                   o_out_present,
    output logic                                   o_final_item,
    output logic                                   o_status,
    output logic [ssr_pkg::OUT_LEN_W-1:0]          o_result_length
);

    localparam int CMD_W = ssr_pkg::cmd_width(MAX_PATTERN, CHAR_BITS, MAX_LENGTH);

    logic [TEXT_W-1:0]               r_pattern_chars;
    logic [ssr_pkg::LEN_W-1:0]       r_pattern_length;
    logic [TEXT_W-1:0]               r_replacement_chars;
    logic [ssr_pkg::LEN_W-1:0]       r_replacement_length;
    logic [ssr_pkg::CAP_W-1:0]       r_buffer_capacity;

    ssr_pkg::t_lens   lens;
    logic             clear, accept;
    logic             cmd_valid, cmd_empty, cmd_pop;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_chars      <= '0;
            r_pattern_length     <= ssr_pkg::PLEN_RESET;
            r_replacement_chars  <= '0;
            r_replacement_length <= '0;
            r_buffer_capacity    <= ssr_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssr_pkg::CFG_PATTERN_CHARS:      r_pattern_chars <= i_cfg_data[TEXT_W-1:0];
                ssr_pkg::CFG_PATTERN_LENGTH:
                    r_pattern_length <= i_cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_REPLACEMENT_CHARS:  r_replacement_chars <= i_cfg_data[TEXT_W-1:0];
                ssr_pkg::CFG_REPLACEMENT_LENGTH:
                    r_replacement_length <= i_cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_BUFFER_CAPACITY:
                    r_buffer_capacity <= i_cfg_data[ssr_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign clear = i_cfg_we && ((i_cfg_index == ssr_pkg::CFG_PATTERN_CHARS)
                             || (i_cfg_index == ssr_pkg::CFG_PATTERN_LENGTH));

    // A zero pattern length behaves as one; lengths above their maxima are clamped.
    always_comb begin
        if (r_pattern_length == '0) begin
            lens.plen = ssr_pkg::LEN_W'(1);
        end else if (r_pattern_length > ssr_pkg::LEN_W'(MAX_PATTERN)) begin
            lens.plen = ssr_pkg::LEN_W'(MAX_PATTERN);
        end else begin
            lens.plen = r_pattern_length;
        end
        if (r_replacement_length > ssr_pkg::LEN_W'(ssr_pkg::REPL_MAX)) begin
            lens.rlen = ssr_pkg::LEN_W'(ssr_pkg::REPL_MAX);
        end else begin
            lens.rlen = r_replacement_length;
        end
    end

    assign accept = push && !full;

    ssr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_BITS   (CHAR_BITS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_lens          (lens),
        .i_pattern       (r_pattern_chars[MAX_PATTERN*CHAR_BITS-1:0]),
        .i_accept        (accept),
        .i_in_char       (i_in_char),
        .i_char_present  (i_char_present),
        .i_end_of_string (i_end_of_string),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd_in)
    );

    ssr_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (ssr_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    ssr_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_BITS   (CHAR_BITS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_lens          (lens),
        .i_repl          (r_replacement_chars),
        .i_capacity      (r_buffer_capacity),
        .i_cmd           (cmd_out),
        .i_cmd_empty     (cmd_empty),
        .o_cmd_pop       (cmd_pop),
        .pop             (pop),
        .empty           (empty),
        .o_out_char      (o_out_char),
        .o_out_present   (o_out_present),
        .o_final_item    (o_final_item),
        .o_status        (o_status),
        .o_result_length (o_result_length)
    );

endmodule

`default_nettype wire
